// ----- rtl/core/loop_trip_count_unit_top_macros.svh -----
// Assertion macros used by the loop trip count unit checker.
`ifndef LOOP_TRIP_COUNT_UNIT_TOP_MACROS_SVH
`define LOOP_TRIP_COUNT_UNIT_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LTCU_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LTCU_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked through reset.
`define LTCU_ASSERT_RST(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ltcu_pkg.sv -----
// Package: widths, codes and pipeline payload types of the loop trip count unit.
package ltcu_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DATA_W          = 32;
    localparam int STEP_W          = 33;
    localparam int ACT_W           = 3;
    localparam int ST_W            = 3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK          = 3'd0;
    localparam logic [ST_W-1:0] ST_STEP_ZERO   = 3'd1;
    localparam logic [ST_W-1:0] ST_DIRECTION   = 3'd2;
    localparam logic [ST_W-1:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [ST_W-1:0] ST_OVERFLOW    = 3'd4;

    // Sideband that rides along the divider chain
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic              runs;
        logic              strict;
        logic              neg;
        logic              start_fit;
        logic [DATA_W-1:0] limit;
        logic [STEP_W-1:0] mag;
    } ltcu_side_t;

    // Divider state: partial remainder and dividend/quotient shift word
    typedef struct packed {
        logic [STEP_W-1:0] rem;
        logic [DATA_W-1:0] dq;
    } ltcu_div_t;

endpackage

// ----- rtl/core/ltcu_prep.sv -----
// Front stage: checks the request, forms distance and step magnitude.
module ltcu_prep import ltcu_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [DATA_W-1:0] start_value,
    input  logic signed [DATA_W-1:0] limit_value,
    input  logic signed [STEP_W-1:0] step_amount,
    input  logic [ACT_W-1:0]         action,
    output logic                     out_valid,
    output ltcu_side_t               side_out,
    output ltcu_div_t                div_out
);

    logic              valid_reg;
    ltcu_side_t        side_reg, side_next;
    ltcu_div_t         div_reg, div_next;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] start_hi;

    always_comb begin
        side_next.neg = step_amount[STEP_W-1];
        side_next.mag = side_next.neg ? (~step_amount + STEP_W'(1)) : step_amount;
        side_next.strict = ~action[0];
        side_next.limit = limit_value;

        // Distance toward the bound, one bit wider than the operands
        if (action[1]) begin
            diff = {start_value[DATA_W-1], start_value} - {limit_value[DATA_W-1], limit_value};
        end else begin
            diff = {limit_value[DATA_W-1], limit_value} - {start_value[DATA_W-1], start_value};
        end
        side_next.runs = !diff[DATA_W] && (!side_next.strict || (diff != '0));

        start_hi = DATA_W'($signed(start_value) >>> (VALUE_WIDTH - 1));
        side_next.start_fit = (start_hi == '0) || (start_hi == '1);

        if (step_amount == '0) begin
            side_next.status = ST_STEP_ZERO;
        end else if (action[2]) begin
            side_next.status = ST_UNSUPPORTED;
        end else if (action[1] != side_next.neg) begin
            side_next.status = ST_DIRECTION;
        end else begin
            side_next.status = ST_OK;
        end

        div_next.rem = '0;
        div_next.dq  = diff[DATA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
            side_reg  <= side_next;
            div_reg   <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign side_out  = side_reg;
    assign div_out   = div_reg;

endmodule

// ----- rtl/core/ltcu_div_cell.sv -----
// Divider cell: resolves one quotient bit and hands the item to the next cell.
module ltcu_div_cell import ltcu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  ltcu_side_t side_in,
    input  ltcu_div_t  div_in,
    output logic       out_valid,
    output ltcu_side_t side_out,
    output ltcu_div_t  div_out
);

    logic              valid_reg;
    ltcu_side_t        side_reg;
    ltcu_div_t         div_reg, div_next;
    logic [STEP_W:0]   trial;
    logic [STEP_W:0]   trial_sub;
    logic              take;

    always_comb begin
        // Shift the next dividend bit into the remainder, subtract if it fits
        trial     = {div_in.rem, div_in.dq[DATA_W-1]};
        trial_sub = trial - {1'b0, side_in.mag};
        take      = trial >= {1'b0, side_in.mag};
        div_next.rem = take ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];
        div_next.dq  = {div_in.dq[DATA_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
            side_reg  <= side_in;
            div_reg   <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign side_out  = side_reg;
    assign div_out   = div_reg;

endmodule

// ----- rtl/core/ltcu_finish.sv -----
// Back end: rounds the quotient into a count and checks the final value range.
module ltcu_finish import ltcu_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  ltcu_side_t        side_in,
    input  ltcu_div_t         div_in,
    output logic              out_valid,
    output logic [DATA_W-1:0] trip_count,
    output logic [ST_W-1:0]   status
);

    localparam int FIN_W = DATA_W + 3;

    logic              a_valid_reg;
    ltcu_side_t        a_side_reg;
    logic [DATA_W:0]   a_trips_reg, a_trips_next;
    logic [STEP_W-1:0] a_over_reg, a_over_next;
    logic              rem_zero;

    logic              m_valid_reg;
    logic [DATA_W-1:0] trip_count_reg, trip_count_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [FIN_W-1:0]  final_val;
    logic [FIN_W-1:0]  final_hi;
    logic              fits;

    // Stage A: count and overshoot past the bound (mag - remainder)
    always_comb begin
        rem_zero = (div_in.rem == '0);
        if (!side_in.runs) begin
            a_trips_next = '0;
            a_over_next  = '0;
        end else if (side_in.strict && rem_zero) begin
            a_trips_next = {1'b0, div_in.dq};
            a_over_next  = '0;
        end else begin
            a_trips_next = {1'b0, div_in.dq} + (DATA_W + 1)'(1);
            a_over_next  = side_in.mag - div_in.rem;
        end
    end

    // Stage B: final value = bound moved on by the overshoot; range check and status
    always_comb begin
        if (a_side_reg.neg) begin
            final_val = {{3{a_side_reg.limit[DATA_W-1]}}, a_side_reg.limit}
                      - {2'b00, a_over_reg};
        end else begin
            final_val = {{3{a_side_reg.limit[DATA_W-1]}}, a_side_reg.limit}
                      + {2'b00, a_over_reg};
        end
        final_hi = FIN_W'($signed(final_val) >>> (VALUE_WIDTH - 1));
        if (!a_side_reg.runs) begin
            fits = a_side_reg.start_fit;
        end else begin
            fits = ((final_hi == '0) || (final_hi == '1)) && !a_trips_reg[DATA_W];
        end

        if (a_side_reg.status != ST_OK) begin
            trip_count_next = '0;
            status_next     = a_side_reg.status;
        end else if (!fits) begin
            trip_count_next = '0;
            status_next     = ST_OVERFLOW;
        end else begin
            trip_count_next = a_trips_reg[DATA_W-1:0];
            status_next     = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg    <= in_valid;
            a_side_reg     <= side_in;
            a_trips_reg    <= a_trips_next;
            a_over_reg     <= a_over_next;
            m_valid_reg    <= a_valid_reg;
            trip_count_reg <= trip_count_next;
            status_reg     <= status_next;
        end
    end

    assign out_valid  = m_valid_reg;
    assign trip_count = trip_count_reg;
    assign status     = status_reg;

endmodule

// ----- rtl/core/loop_trip_count_unit_top.sv -----
// Top level of the loop trip count unit: front stage, divider cell chain, back end.
//
// Usage:
//   The s_ channel takes one request per cycle while s_ready is high: start value,
//   bound, signed step and the comparison code (less, less-or-equal, greater,
//   greater-or-equal). The m_ channel returns one result per request, in order:
//   iteration count and status. A request passes one front stage, one divider cell
//   per quotient bit (32 cells in a row) and two back-end stages to reach m_valid.
//   Throughput is one request per cycle while the row is not stalled; each cell
//   resolves one quotient bit per item and the items march down the row together.
//   Reset (aresetn low at a clock edge) empties the pipeline; requests in flight are
//   dropped, as none is held across reset.
//   When the receiver stalls with a result pending, the whole row holds and
//   s_ready drops in the same cycle; bubbles inside the row are not squeezed out,
//   as the row only moves as a whole. s_ready = !m_valid || m_ready.
//   VALUE_WIDTH sets the signed range the final induction value must stay in.
module loop_trip_count_unit_top import ltcu_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_start_value,
    input  logic signed [DATA_W-1:0] s_limit_value,
    input  logic signed [STEP_W-1:0] s_step_amount,
    input  logic [ACT_W-1:0]         s_action,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DATA_W-1:0]        m_trip_count,
    output logic [ST_W-1:0]          m_status
);

    // Advance everything unless a result waits on a stalled receiver
    logic       advance;
    logic       valid_w [0:DATA_W];
    ltcu_side_t side_w  [0:DATA_W];
    ltcu_div_t  div_w   [0:DATA_W];

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    ltcu_prep #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_prep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .in_valid    (s_valid),
        .start_value (s_start_value),
        .limit_value (s_limit_value),
        .step_amount (s_step_amount),
        .action      (s_action),
        .out_valid   (valid_w[0]),
        .side_out    (side_w[0]),
        .div_out     (div_w[0])
    );

    // One cell per quotient bit, MSB first
    for (genvar i = 0; i < DATA_W; i++) begin : g_cell
        ltcu_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (advance),
            .in_valid  (valid_w[i]),
            .side_in   (side_w[i]),
            .div_in    (div_w[i]),
            .out_valid (valid_w[i+1]),
            .side_out  (side_w[i+1]),
            .div_out   (div_w[i+1])
        );
    end

    ltcu_finish #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_finish (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .in_valid   (valid_w[DATA_W]),
        .side_in    (side_w[DATA_W]),
        .div_in     (div_w[DATA_W]),
        .out_valid  (m_valid),
        .trip_count (m_trip_count),
        .status     (m_status)
    );

endmodule

// ----- rtl/core/ltcu_checker.sv -----
// Port-level checker for the loop trip count unit, bound to the top level.
`include "loop_trip_count_unit_top_macros.svh"

module ltcu_checker import ltcu_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_trip_count,
    input logic [ST_W-1:0]   m_status
);

    `LTCU_ASSERT_NXT(a_hold_stalled, m_valid && !m_ready, m_valid && $stable(m_trip_count) && $stable(m_status), "stalled result changed")
    `LTCU_ASSERT_IMP(a_reject_zero, m_valid && (m_status != ST_OK), m_trip_count == '0, "rejected request carries a nonzero count")
    `LTCU_ASSERT_IMP(a_status_code, m_valid, (m_status == ST_OK) || (m_status == ST_STEP_ZERO) || (m_status == ST_DIRECTION) || (m_status == ST_UNSUPPORTED) || (m_status == ST_OVERFLOW), "undefined status code")
    `LTCU_ASSERT_IMP(a_stall_blocks, m_valid && !m_ready, !s_ready, "request taken while the row is stalled")
    `LTCU_ASSERT_RST(a_reset_empty, !aresetn, !m_valid, "result present right after reset")

endmodule

bind loop_trip_count_unit_top ltcu_checker u_ltcu_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_trip_count (m_trip_count),
    .m_status     (m_status)
);

// ----- tb/loop_trip_count_unit_top_tb.sv -----
// Self-checking testbench for the loop trip count unit: directed loop table, then random loops.
`timescale 1ns / 100ps

module loop_trip_count_unit_top_tb;
    import ltcu_pkg::*;

    localparam int VAL_W        = VALUE_WIDTH_DEF;
    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 1725;
    localparam int DRAIN_CYCLES = 48;      // wait after the last expected result, with margin
    localparam int CYCLE_LIMIT  = 600000;

    // Comparison codes on s_action; codes above CMP_GE are not supported.
    typedef enum logic [ACT_W-1:0] {
        CMP_LT   = 3'd0,
        CMP_LE   = 3'd1,
        CMP_GT   = 3'd2,
        CMP_GE   = 3'd3,
        CMP_RSV4 = 3'd4,
        CMP_RSV5 = 3'd5,
        CMP_RSV6 = 3'd6,
        CMP_RSV7 = 3'd7
    } loop_cmp_e;

    // Receiver behavior, switched at random intervals.
    typedef enum int {
        SINK_OPEN,      // always ready
        SINK_MOSTLY,    // ready at random, three times in four
        SINK_SPARSE,    // ready at random, one time in four
        SINK_BURSTY     // long holds broken by short ready windows
    } sink_mode_e;

    typedef struct packed {
        logic [DATA_W-1:0] trip;
        logic [ST_W-1:0]   status;
    } loop_result_t;

    // One directed loop; the expected result is spelled out only where typed is set.
    typedef struct packed {
        logic [DATA_W-1:0] start_v;
        logic [DATA_W-1:0] limit_v;
        logic [STEP_W-1:0] step_v;
        logic [ACT_W-1:0]  cmp;
        logic              typed;
        logic [DATA_W-1:0] trip;
        logic [ST_W-1:0]   status;
    } loop_row_t;

    // Final induction value must stay inside the signed VAL_W range.
    localparam logic signed [79:0] VALUE_HI = (80'sd1 <<< (VAL_W - 1)) - 80'sd1;
    localparam logic signed [79:0] VALUE_LO = -(80'sd1 <<< (VAL_W - 1));
    localparam logic signed [79:0] TRIP_MAX = 80'sd4294967295;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_start_value = '0;
    logic signed [DATA_W-1:0] s_limit_value = '0;
    logic signed [STEP_W-1:0] s_step_amount = '0;
    logic [ACT_W-1:0]         s_action      = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [DATA_W-1:0]        m_trip_count;
    logic [ST_W-1:0]          m_status;

    loop_result_t expected_results[$];
    loop_result_t oldest_result;
    int           mismatches = 0;
    int           burst_left = 0;
    int           cycle_count = 0;

    sink_mode_e   sink_mode      = SINK_OPEN;
    int           sink_mode_left = 0;
    int           sink_run       = 0;
    logic         sink_hold      = 1'b0;

    // Directed loops: error codes in check order, zero-trip loops, small counts
    // for each comparison, then the extremes of start, bound and step.
    loop_row_t directed_rows [N_DIRECTED] = '{
        // zero step wins over everything else
        '{0, 10, 0, CMP_LT, 1'b1, 0, ST_STEP_ZERO},
        '{0, 10, 0, CMP_RSV7, 1'b1, 0, ST_STEP_ZERO},
        // unsupported comparison wins over direction
        '{0, 10, 1, CMP_RSV4, 1'b1, 0, ST_UNSUPPORTED},
        '{0, 10, -1, CMP_RSV5, 1'b1, 0, ST_UNSUPPORTED},
        '{0, 10, 33'h1_0000_0000, CMP_RSV6, 1'b1, 0, ST_UNSUPPORTED},
        // step points the wrong way
        '{0, 10, -1, CMP_LT, 1'b1, 0, ST_DIRECTION},
        '{10, 0, -1, CMP_LE, 1'b1, 0, ST_DIRECTION},
        '{10, 0, 1, CMP_GT, 1'b1, 0, ST_DIRECTION},
        '{10, 0, 33'h0_FFFF_FFFF, CMP_GE, 1'b1, 0, ST_DIRECTION},
        // start already fails the comparison
        '{5, 5, 1, CMP_LT, 1'b1, 0, ST_OK},
        '{5, 5, -1, CMP_GT, 1'b1, 0, ST_OK},
        '{6, 5, 1, CMP_LE, 1'b1, 0, ST_OK},
        '{4, 5, -1, CMP_GE, 1'b1, 0, ST_OK},
        // short loops, distance not a multiple of the step
        '{0, 10, 3, CMP_LT, 1'b0, 0, ST_OK},
        '{0, 10, 3, CMP_LE, 1'b0, 0, ST_OK},
        '{10, -7, -4, CMP_GT, 1'b0, 0, ST_OK},
        '{10, -7, -4, CMP_GE, 1'b0, 0, ST_OK},
        // full 32-bit span with unit step: fits when strict, overflows when inclusive
        '{32'h8000_0000, 32'h7FFF_FFFF, 1, CMP_LT, 1'b1, 32'hFFFF_FFFF, ST_OK},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1, CMP_LE, 1'b1, 0, ST_OVERFLOW},
        '{32'h7FFF_FFFF, 32'h8000_0000, -1, CMP_GT, 1'b1, 32'hFFFF_FFFF, ST_OK},
        '{32'h7FFF_FFFF, 32'h8000_0000, -1, CMP_GE, 1'b1, 0, ST_OVERFLOW},
        // one trip that steps just past the top
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, CMP_LE, 1'b1, 0, ST_OVERFLOW},
        // step extremes
        '{-1, 0, 33'h0_8000_0000, CMP_LE, 1'b0, 0, ST_OK},
        '{0, 0, 33'h1_8000_0000, CMP_GE, 1'b0, 0, ST_OK},
        '{32'h7FFF_FFFF, 32'h8000_0000, 33'h1_0000_0000, CMP_GT, 1'b0, 0, ST_OK}
    };

    loop_trip_count_unit_top #(
        .VALUE_WIDTH(VAL_W)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_value (s_start_value),
        .s_limit_value (s_limit_value),
        .s_step_amount (s_step_amount),
        .s_action      (s_action),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_trip_count  (m_trip_count),
        .m_status      (m_status)
    );

    always #4 aclk = ~aclk;

    // Work out the trip count and status of one loop. All arithmetic runs at
    // 80 bits so that neither the distance nor trips * step can wrap.
    function automatic loop_result_t predict_trip_count(
        input logic signed [DATA_W-1:0] start_v,
        input logic signed [DATA_W-1:0] limit_v,
        input logic signed [STEP_W-1:0] step_v,
        input logic [ACT_W-1:0]         cmp
    );
        logic signed [79:0] first_w;
        logic signed [79:0] bound_w;
        logic signed [79:0] step_w;
        logic signed [79:0] mag;
        logic signed [79:0] span_w;
        logic signed [79:0] trips;
        logic signed [79:0] last_w;
        logic               strict;
        loop_result_t       res;
        first_w    = 80'(start_v);
        bound_w    = 80'(limit_v);
        step_w     = 80'(step_v);
        res.trip   = '0;
        res.status = ST_OK;
        if (step_w == 0) begin
            res.status = ST_STEP_ZERO;
        end else if (cmp > CMP_GE) begin
            res.status = ST_UNSUPPORTED;
        end else if ((cmp <= CMP_LE) != (step_w > 0)) begin
            // less-type loops count up, greater-type loops count down
            res.status = ST_DIRECTION;
        end else begin
            mag    = (step_w < 0) ? -step_w : step_w;
            span_w = (cmp <= CMP_LE) ? bound_w - first_w : first_w - bound_w;
            strict = (cmp == CMP_LT) || (cmp == CMP_GT);
            trips  = '0;
            if (strict && span_w > 0)
                trips = (span_w + mag - 1) / mag;
            else if (!strict && span_w >= 0)
                trips = span_w / mag + 1;
            last_w = (step_w > 0) ? first_w + trips * mag : first_w - trips * mag;
            if (last_w < VALUE_LO || last_w > VALUE_HI || trips > TRIP_MAX)
                res.status = ST_OVERFLOW;
            else
                res.trip = trips[DATA_W-1:0];
        end
        return res;
    endfunction

    // Present one request, pacing the sender in bursts with gaps between them.
    // Call at a rising edge; returns at the edge that accepts the request.
    task automatic send_loop(
        input logic signed [DATA_W-1:0] start_v,
        input logic signed [DATA_W-1:0] limit_v,
        input logic signed [STEP_W-1:0] step_v,
        input logic [ACT_W-1:0]         cmp,
        input loop_result_t             want
    );
        int gap;
        if (burst_left == 0) begin
            // Mostly short gaps; now and then a long one.
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            // Mostly short bursts; now and then a long back-to-back stretch.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_start_value <= start_v;
        s_limit_value <= limit_v;
        s_step_amount <= step_v;
        s_action      <= cmp;
        // Hold the request until the edge at which ready is seen high.
        do @(posedge aclk); while (!s_ready);
        expected_results.insert(expected_results.size(), want);
    endtask

    // Receiver: stall on a pattern of its own, changing mode every so often.
    always @(posedge aclk) begin
        if (sink_mode_left == 0) begin
            sink_mode      = sink_mode_e'($urandom_range(0, 3));
            sink_mode_left = $urandom_range(32, 400);
        end
        sink_mode_left--;
        case (sink_mode)
            SINK_OPEN: begin
                m_ready <= 1'b1;
            end
            SINK_MOSTLY: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            SINK_SPARSE: begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                // Alternate long holds with short ready windows.
                if (sink_run == 0) begin
                    sink_hold = !sink_hold;
                    sink_run  = sink_hold ? $urandom_range(1, 40) : $urandom_range(1, 10);
                end
                sink_run--;
                m_ready <= !sink_hold;
            end
        endcase
    end

    // Result checker: compare each accepted result with the oldest pending one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got trip_count %0d status %0d",
                         $time, m_trip_count, m_status);
                mismatches++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (m_trip_count !== oldest_result.trip) begin
                    $display("%0t: trip_count mismatch: expected %0d, got %0d",
                             $time, oldest_result.trip, m_trip_count);
                    mismatches++;
                end
                if (m_status !== oldest_result.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, oldest_result.status, m_status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results pending", $time, expected_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Stimulus: reset, directed table, random loops, then drain and report.
    initial begin
        loop_row_t                row;
        loop_result_t             want;
        logic signed [DATA_W-1:0] start_v;
        logic signed [DATA_W-1:0] limit_v;
        logic [STEP_W-1:0]        step_mag;
        logic signed [STEP_W-1:0] step_v;
        logic [ACT_W-1:0]         cmp_v;
        logic                     count_up;
        int                       sel;
        int                       edge_off;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table; typed rows carry their own expectation.
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            if (row.typed) begin
                want.trip   = row.trip;
                want.status = row.status;
            end else begin
                want = predict_trip_count(row.start_v, row.limit_v, row.step_v, row.cmp);
            end
            send_loop(row.start_v, row.limit_v, row.step_v, row.cmp, want);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // Mostly supported comparisons; the rest exercise the reject path.
            cmp_v = ($urandom_range(0, 11) == 0) ? ACT_W'($urandom_range(4, 7))
                                                 : ACT_W'($urandom_range(0, 3));

            // Start and bound: fully random, close together, near the range
            // edges, or small values around zero.
            case ($urandom_range(0, 5))
                0, 1: begin
                    start_v = $urandom();
                    limit_v = $urandom();
                end
                2, 3: begin
                    start_v = $urandom();
                    limit_v = start_v + $urandom_range(0, 400) - 200;
                end
                4: begin
                    edge_off = $urandom_range(0, 300);
                    start_v  = $urandom_range(0, 1) ? 32'h8000_0000 + edge_off
                                                    : 32'h7FFF_FFFF - edge_off;
                    limit_v  = $urandom_range(0, 1) ? $urandom()
                                                    : ~start_v + $urandom_range(0, 300);
                end
                default: begin
                    start_v = $urandom_range(0, 1000) - 500;
                    limit_v = $urandom_range(0, 1000) - 500;
                end
            endcase

            // Step magnitude: small most of the time so counts stay meaningful.
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                step_mag = '0;
            end else if (sel < 10) begin
                step_mag = STEP_W'($urandom_range(1, 16));
            end else if (sel < 14) begin
                step_mag = STEP_W'($urandom_range(17, 70000));
            end else if (sel < 18) begin
                step_mag = {1'b0, 32'($urandom())};
            end else begin
                case ($urandom_range(0, 3))
                    0:       step_mag = 33'h0_8000_0000;
                    1:       step_mag = 33'h0_FFFF_FFFF;
                    2:       step_mag = 33'h0_7FFF_FFFF;
                    default: step_mag = 33'd1;
                endcase
            end

            // Point the step the right way nine times in ten.
            count_up = (cmp_v <= CMP_LE);
            if ($urandom_range(0, 9) == 0)
                count_up = !count_up;
            step_v = count_up ? step_mag : -step_mag;

            // Drop in raw 33-bit patterns, including the most negative step.
            if (sel == 19) begin
                step_v[DATA_W-1:0] = $urandom();
                step_v[STEP_W-1]   = 1'($urandom_range(0, 1));
            end else if (sel == 18 && $urandom_range(0, 3) == 0) begin
                step_v = 33'h1_0000_0000;
            end

            want = predict_trip_count(start_v, limit_v, step_v, cmp_v);
            send_loop(start_v, limit_v, step_v, cmp_v, want);
        end

        // Release the channel and wait for every pending result.
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        // Allow a spurious late result to show up.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
